>>> rtl/bgu_pkg.sv
// ----------------------------------------------------------------------------
// bgu_pkg
// Shared types and constants of the bilinear grid upscaler.
// ----------------------------------------------------------------------------
package bgu_pkg;

    // grid and store geometry
    localparam int GRID_MAX    = 16;
    localparam int STORE_DEPTH = GRID_MAX * GRID_MAX;
    localparam int IDX_W       = 8;
    localparam int GIDX_W      = 4;
    localparam int G_W         = 5;
    localparam int OS_W        = 9;
    localparam int OUT_MAX     = 256;

    // arithmetic widths
    localparam int SAMPLE_W    = 24;
    localparam int COORD_W     = 8;
    localparam int SPAN_W      = 8;
    localparam int NUM_W       = 12;
    localparam int FRAC_W      = 16;
    localparam int QUO_W       = NUM_W + FRAC_W;
    localparam int DIV_STAGES  = QUO_W / 2;

    // queue between front and back
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    // item kinds
    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } bgu_kind_t;

    // register map index
    typedef enum logic {
        REG_GRID_SIZE = 1'b0,
        REG_OUT_SIZE  = 1'b1
    } bgu_reg_t;

    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    grid_index;
        logic [SAMPLE_W-1:0] sample;
        logic [COORD_W-1:0]  out_x;
        logic [COORD_W-1:0]  out_y;
    } bgu_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
    } bgu_out_t;

    // effective configuration
    typedef struct packed {
        logic [G_W-1:0]    g;
        logic [GIDX_W-1:0] gm1;
        logic [SPAN_W-1:0] span;
        logic [SPAN_W-1:0] divisor;
    } bgu_cfg_t;

    // queue entry: item plus scaled coordinates
    typedef struct packed {
        bgu_in_t          item;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
    } bgu_entry_t;

    // queue status seen by the back part
    typedef struct packed {
        logic       nonempty;
        bgu_entry_t head;
    } bgu_q_stat_t;

endpackage

>>> rtl/bgu_div.sv
// ----------------------------------------------------------------------------
// bgu_div
// Pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module bgu_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [bgu_pkg::NUM_W-1:0]     num,
    input  logic [bgu_pkg::SPAN_W-1:0]    divisor,
    output logic [bgu_pkg::QUO_W-1:0]     quo
);

    logic [bgu_pkg::SPAN_W-1:0] rem_reg [bgu_pkg::DIV_STAGES];
    logic [bgu_pkg::QUO_W-1:0]  dq_reg  [bgu_pkg::DIV_STAGES];

    genvar i;
    generate
        for (i = 0; i < bgu_pkg::DIV_STAGES; i++) begin : g_stage
            logic [bgu_pkg::SPAN_W-1:0] rem_in;
            logic [bgu_pkg::QUO_W-1:0]  dq_in;
            logic [bgu_pkg::SPAN_W:0]   t1, t2, r1, r2;
            logic                       ge1, ge2;
            logic [bgu_pkg::QUO_W-1:0]  dq1, dq_next;
            logic [bgu_pkg::SPAN_W-1:0] rem_next;

            // stage input
            if (i == 0) begin : g_first
                assign rem_in = '0;
                assign dq_in  = {num, {bgu_pkg::FRAC_W{1'b0}}};
            end else begin : g_rest
                assign rem_in = rem_reg[i-1];
                assign dq_in  = dq_reg[i-1];
            end

            // two compare and subtract steps
            always_comb begin
                t1       = {rem_in, dq_in[bgu_pkg::QUO_W-1]};
                ge1      = t1 >= {1'b0, divisor};
                r1       = ge1 ? (t1 - {1'b0, divisor}) : t1;
                dq1      = {dq_in[bgu_pkg::QUO_W-2:0], ge1};
                t2       = {r1[bgu_pkg::SPAN_W-1:0], dq1[bgu_pkg::QUO_W-1]};
                ge2      = t2 >= {1'b0, divisor};
                r2       = ge2 ? (t2 - {1'b0, divisor}) : t2;
                dq_next  = {dq1[bgu_pkg::QUO_W-2:0], ge2};
                rem_next = r2[bgu_pkg::SPAN_W-1:0];
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next;
                    dq_reg[i]  <= dq_next;
                end
            end
        end
    endgenerate

    assign quo = dq_reg[bgu_pkg::DIV_STAGES-1];

endmodule

>>> rtl/bgu_front.sv
// ----------------------------------------------------------------------------
// bgu_front
// Accepts items, scales query coordinates and queues them for the back part.
// ----------------------------------------------------------------------------
module bgu_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bgu_pkg::bgu_cfg_t     cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bgu_pkg::bgu_in_t      s_data,
    input  logic                  pop,
    output bgu_pkg::bgu_q_stat_t  q_stat
);

    bgu_pkg::bgu_entry_t          q_mem [bgu_pkg::Q_DEPTH];
    logic [bgu_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bgu_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bgu_pkg::Q_CNT_W-1:0]  count_reg, count_next;
    logic                         push;
    logic [bgu_pkg::COORD_W-1:0]  cx, cy;
    logic [bgu_pkg::NUM_W-1:0]    num_x, num_y;
    bgu_pkg::bgu_entry_t          entry;

    // clamp to the output and scale by grid side minus one
    always_comb begin
        cx    = (s_data.out_x > cfg.span) ? cfg.span : s_data.out_x;
        cy    = (s_data.out_y > cfg.span) ? cfg.span : s_data.out_y;
        num_x = bgu_pkg::NUM_W'(cx) * bgu_pkg::NUM_W'(cfg.gm1);
        num_y = bgu_pkg::NUM_W'(cy) * bgu_pkg::NUM_W'(cfg.gm1);
        entry.item  = s_data;
        entry.num_x = num_x;
        entry.num_y = num_y;
    end

    assign s_ready = (count_reg != bgu_pkg::Q_CNT_W'(bgu_pkg::Q_DEPTH));
    assign push    = s_valid && s_ready;

    // queue pointers
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{(bgu_pkg::Q_CNT_W-1){1'b0}}, push}
                                - {{(bgu_pkg::Q_CNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

    assign q_stat.nonempty = (count_reg != '0);
    assign q_stat.head     = q_mem[rd_ptr_reg];

endmodule

>>> rtl/bgu_back.sv
// ----------------------------------------------------------------------------
// bgu_back
// Divides, stores loads, reads four neighbours and blends them into one result.
// ----------------------------------------------------------------------------
module bgu_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bgu_pkg::bgu_cfg_t     cfg,
    input  bgu_pkg::bgu_q_stat_t  q_stat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bgu_pkg::bgu_out_t     m_data
);

    localparam int SW = bgu_pkg::SAMPLE_W;
    localparam int FW = bgu_pkg::FRAC_W;
    localparam int TW = SW + FW;

    logic                        en;
    logic [bgu_pkg::QUO_W-1:0]   qx, qy;
    logic                        v_reg [bgu_pkg::DIV_STAGES];
    bgu_pkg::bgu_in_t            meta_reg [bgu_pkg::DIV_STAGES];
    logic                        dv;
    bgu_pkg::bgu_in_t            dm;

    // neighbour selection
    logic [bgu_pkg::GIDX_W-1:0]  x0, y0, x1, y1;
    logic [bgu_pkg::G_W-1:0]     x0p1, y0p1;
    logic [bgu_pkg::IDX_W-1:0]   a00, a01, a10, a11;
    logic [bgu_pkg::IDX_W:0]     row0, row1;

    logic [SW-1:0] mem00 [bgu_pkg::STORE_DEPTH];
    logic [SW-1:0] mem01 [bgu_pkg::STORE_DEPTH];
    logic [SW-1:0] mem10 [bgu_pkg::STORE_DEPTH];
    logic [SW-1:0] mem11 [bgu_pkg::STORE_DEPTH];

    logic [SW-1:0]     s00_reg, s01_reg, s10_reg, s11_reg;
    logic [FW-1:0]     wx_m_reg, wy_m_reg, wy_b1_reg;
    logic              vm_reg, vb1_reg, vb2_reg;
    bgu_pkg::bgu_in_t  meta_m_reg, meta_b1_reg, meta_b2_reg;

    logic signed [SW:0]      dt, db;
    logic signed [TW+1:0]    pt, pb, top_full, bot_full;
    logic [TW-1:0]           top_reg, bot_reg, top_b2_reg;

    logic signed [TW:0]      d2;
    logic [SW+FW-1:0]        plo_next, plo_reg;
    logic signed [TW-SW:0]   dhi;
    logic signed [TW-SW+FW+1:0] phi_next, phi_reg;

    localparam int SUM_W = TW + FW + 2;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        rnd;
    logic [SW-1:0]           value;

    logic              m_valid_reg, m_valid_next;
    bgu_pkg::bgu_out_t m_data_reg;

    // whole back part advances unless a result waits
    assign en  = !m_valid_reg || m_ready;
    assign pop = en && q_stat.nonempty;

    bgu_div u_div_x (
        .aclk    (aclk),
        .en      (en),
        .num     (q_stat.head.num_x),
        .divisor (cfg.divisor),
        .quo     (qx)
    );

    bgu_div u_div_y (
        .aclk    (aclk),
        .en      (en),
        .num     (q_stat.head.num_y),
        .divisor (cfg.divisor),
        .quo     (qy)
    );

    // item travels beside the divider
    genvar i;
    generate
        for (i = 0; i < bgu_pkg::DIV_STAGES; i++) begin : g_meta
            logic             v_in;
            bgu_pkg::bgu_in_t meta_in;

            if (i == 0) begin : g_first
                assign v_in    = q_stat.nonempty;
                assign meta_in = q_stat.head.item;
            end else begin : g_rest
                assign v_in    = v_reg[i-1];
                assign meta_in = meta_reg[i-1];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (en) begin
                    v_reg[i] <= v_in;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    meta_reg[i] <= meta_in;
                end
            end
        end
    endgenerate

    assign dv = v_reg[bgu_pkg::DIV_STAGES-1];
    assign dm = meta_reg[bgu_pkg::DIV_STAGES-1];

    // lower and clamped upper neighbours, row-major addresses
    always_comb begin
        x0   = qx[FW +: bgu_pkg::GIDX_W];
        y0   = qy[FW +: bgu_pkg::GIDX_W];
        x0p1 = {1'b0, x0} + 1'b1;
        y0p1 = {1'b0, y0} + 1'b1;
        x1   = (x0p1 > {1'b0, cfg.gm1}) ? cfg.gm1 : x0p1[bgu_pkg::GIDX_W-1:0];
        y1   = (y0p1 > {1'b0, cfg.gm1}) ? cfg.gm1 : y0p1[bgu_pkg::GIDX_W-1:0];
        row0 = (bgu_pkg::IDX_W+1)'(y0) * (bgu_pkg::IDX_W+1)'(cfg.g);
        row1 = (bgu_pkg::IDX_W+1)'(y1) * (bgu_pkg::IDX_W+1)'(cfg.g);
        a00  = bgu_pkg::IDX_W'(row0 + {5'd0, x0});
        a01  = bgu_pkg::IDX_W'(row0 + {5'd0, x1});
        a10  = bgu_pkg::IDX_W'(row1 + {5'd0, x0});
        a11  = bgu_pkg::IDX_W'(row1 + {5'd0, x1});
    end

    // sample store, one copy per neighbour, loads write all copies in order
    always_ff @(posedge aclk) begin
        if (en && dv && (dm.kind == bgu_pkg::KIND_LOAD)) begin
            mem00[dm.grid_index] <= dm.sample;
            mem01[dm.grid_index] <= dm.sample;
            mem10[dm.grid_index] <= dm.sample;
            mem11[dm.grid_index] <= dm.sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s00_reg    <= mem00[a00];
            s01_reg    <= mem01[a01];
            s10_reg    <= mem10[a10];
            s11_reg    <= mem11[a11];
            wx_m_reg   <= qx[FW-1:0];
            wy_m_reg   <= qy[FW-1:0];
            meta_m_reg <= dm;
        end
    end

    // horizontal blend of both rows
    always_comb begin
        dt       = $signed({1'b0, s01_reg}) - $signed({1'b0, s00_reg});
        db       = $signed({1'b0, s11_reg}) - $signed({1'b0, s10_reg});
        pt       = (TW+2)'(dt) * (TW+2)'($signed({1'b0, wx_m_reg}));
        pb       = (TW+2)'(db) * (TW+2)'($signed({1'b0, wx_m_reg}));
        top_full = $signed({2'b00, s00_reg, {FW{1'b0}}}) + pt;
        bot_full = $signed({2'b00, s10_reg, {FW{1'b0}}}) + pb;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            top_reg     <= top_full[TW-1:0];
            bot_reg     <= bot_full[TW-1:0];
            wy_b1_reg   <= wy_m_reg;
            meta_b1_reg <= meta_m_reg;
        end
    end

    // vertical blend split into two partial products
    always_comb begin
        d2       = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});
        dhi      = d2[TW:SW];
        plo_next = (SW+FW)'(d2[SW-1:0]) * (SW+FW)'(wy_b1_reg);
        phi_next = (TW-SW+FW+2)'(dhi) * (TW-SW+FW+2)'($signed({1'b0, wy_b1_reg}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg     <= plo_next;
            phi_reg     <= phi_next;
            top_b2_reg  <= top_reg;
            meta_b2_reg <= meta_b1_reg;
        end
    end

    // final sum, round half up, saturate
    always_comb begin
        sum   = $signed({2'b00, top_b2_reg, {FW{1'b0}}})
              + $signed({{(SUM_W-SW-FW){1'b0}}, plo_reg})
              + ($signed(SUM_W'(phi_reg)) <<< SW);
        rnd   = $unsigned(sum) + (SUM_W'(1) << (2*FW-1));
        value = (rnd[SUM_W-1:2*FW+SW] != '0) ? {SW{1'b1}} : rnd[2*FW +: SW];
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg  <= 1'b0;
            vb1_reg <= 1'b0;
            vb2_reg <= 1'b0;
        end else if (en) begin
            vm_reg  <= dv;
            vb1_reg <= vm_reg;
            vb2_reg <= vb1_reg;
        end
    end

    // output register, loads give no result
    always_comb begin
        m_valid_next = m_valid_reg;
        if (en) begin
            m_valid_next = vb2_reg && (meta_b2_reg.kind == bgu_pkg::KIND_QUERY);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.value   <= value;
            m_data_reg.pixel_x <= meta_b2_reg.out_x;
            m_data_reg.pixel_y <= meta_b2_reg.out_y;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/bilinear_grid_upscaler.sv
// ----------------------------------------------------------------------------
// bilinear_grid_upscaler
// Align-corners bilinear upscaling of a square sample grid.
// ----------------------------------------------------------------------------
// One item is taken every clock while the queue has room: loads write a
// sample, queries return one interpolated pixel. A query passes through the
// queue write, then two 28-bit divider pipelines of 14 stages at two quotient
// bits each, one store read, two blend stages and the output register.
// Loads pass through the same pipe, so a query sees exactly the loads taken
// before it. There is no clearing pass after reset: the store holds nothing
// defined until loaded. Registers: grid_size at 0x0, out_size at 0x4; write
// them only while no item is in flight.
module bilinear_grid_upscaler (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  bgu_pkg::bgu_in_t         s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output bgu_pkg::bgu_out_t        m_data
);

    logic [bgu_pkg::G_W-1:0]   grid_size_reg, grid_size_next;
    logic [bgu_pkg::OS_W-1:0]  out_size_reg, out_size_next;
    logic                      wr_en;
    bgu_pkg::bgu_reg_t         reg_sel;
    bgu_pkg::bgu_cfg_t         cfg;
    logic [bgu_pkg::OS_W-1:0]  os_sat;
    logic [bgu_pkg::OS_W-1:0]  span9;
    bgu_pkg::bgu_q_stat_t      q_stat;
    logic                      pop;

    // register port
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = bgu_pkg::bgu_reg_t'(paddr[2]);

    always_comb begin
        grid_size_next = grid_size_reg;
        out_size_next  = out_size_reg;
        prdata         = '0;
        case (reg_sel)
            bgu_pkg::REG_GRID_SIZE: begin
                prdata = {27'd0, grid_size_reg};
                if (wr_en) grid_size_next = pwdata[bgu_pkg::G_W-1:0];
            end
            bgu_pkg::REG_OUT_SIZE: begin
                prdata = {23'd0, out_size_reg};
                if (wr_en) out_size_next = pwdata[bgu_pkg::OS_W-1:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= bgu_pkg::G_W'(10);
            out_size_reg  <= bgu_pkg::OS_W'(160);
        end else begin
            grid_size_reg <= grid_size_next;
            out_size_reg  <= out_size_next;
        end
    end

    // effective sizes
    always_comb begin
        if (grid_size_reg == '0) begin
            cfg.g = bgu_pkg::G_W'(1);
        end else if (grid_size_reg > bgu_pkg::G_W'(bgu_pkg::GRID_MAX)) begin
            cfg.g = bgu_pkg::G_W'(bgu_pkg::GRID_MAX);
        end else begin
            cfg.g = grid_size_reg;
        end
        cfg.gm1 = bgu_pkg::GIDX_W'(cfg.g - 1'b1);
        os_sat  = (out_size_reg > bgu_pkg::OS_W'(bgu_pkg::OUT_MAX))
                ? bgu_pkg::OS_W'(bgu_pkg::OUT_MAX) : out_size_reg;
        span9   = (os_sat == '0) ? '0 : os_sat - 1'b1;
        cfg.span    = span9[bgu_pkg::SPAN_W-1:0];
        cfg.divisor = (cfg.span == '0) ? bgu_pkg::SPAN_W'(1) : cfg.span;
    end

    bgu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .pop     (pop),
        .q_stat  (q_stat)
    );

    bgu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_stat  (q_stat),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // checks
    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_stat.nonempty)
        else $error("queue popped while empty");

    a_full_holds_items: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_stat.nonempty)
        else $error("input stalled with an empty queue");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    a_stall_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !pop)
        else $error("queue popped while result stalled");

endmodule
